### hdl/tcm_pkg.sv
// shared constants for the triangle coverage 3x3 mask block
package tcm_pkg;

  // screen bound registers
  localparam int REG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [REG_BITS-1:0]     screen_max_t;

  localparam cfg_idx_t CFG_SCREEN_X_MAX = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_SCREEN_Y_MAX = cfg_idx_t'(1);

  localparam screen_max_t SCREEN_X_MAX_RST = screen_max_t'(639);
  localparam screen_max_t SCREEN_Y_MAX_RST = screen_max_t'(479);

  localparam int MASK_BITS = 9;
  typedef logic [MASK_BITS-1:0] cover_mask_t;

endpackage

### hdl/tcm_if.sv
// valid/ready channel interfaces for the coverage input, result and register write port

interface tcm_in_if #(
  parameter int COORD_BITS = 12,
  parameter int INDEX_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [INDEX_BITS-1:0] pixel_col;
  logic signed [INDEX_BITS-1:0] pixel_row;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vert_a_x;
  logic signed [COORD_BITS-1:0] vert_a_y;
  logic signed [COORD_BITS-1:0] vert_b_x;
  logic signed [COORD_BITS-1:0] vert_b_y;
  logic signed [COORD_BITS-1:0] vert_c_x;
  logic signed [COORD_BITS-1:0] vert_c_y;

  modport source (
    output valid, pixel_col, pixel_row, point_x, point_y,
           vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
    input  ready
  );
  modport sink (
    input  valid, pixel_col, pixel_row, point_x, point_y,
           vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
    output ready
  );
endinterface

interface tcm_out_if import tcm_pkg::*; ();
  logic        valid;
  logic        ready;
  cover_mask_t cover_mask;
  logic        centre_in_screen;

  modport source (output valid, cover_mask, centre_in_screen, input ready);
  modport sink (input valid, cover_mask, centre_in_screen, output ready);
endinterface

interface tcm_cfg_if import tcm_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  screen_max_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/triangle_coverage_3x3_mask.sv
// top level: pipelined triangle edge-function coverage of a 3x3 pixel neighborhood
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   pixel index, test point, vertices a/b/c
//   out_chan  out  valid/ready   cover_mask[8:0], centre_in_screen
//   cfg_chan  in   valid/ready   index, data (screen_x_max, screen_y_max)
//
// four register stages: deltas and bound checks, products, edge values,
// then the nine neighbor sums and signs into the output register.
// one transfer per cycle sustained while out_chan is ready.
// rst_n is synchronous; it empties the pipe and reloads 639 / 479 into the bounds.
// each stage advances when it is empty or the stage after it advances, so a
// stall on out_chan backs up stage by stage and nothing is lost or repeated.
module triangle_coverage_3x3_mask import tcm_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int INDEX_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  tcm_in_if.sink     in_chan,
  tcm_out_if.source  out_chan,
  tcm_cfg_if.sink    cfg_chan
);

  localparam int W1 = COORD_BITS + 1;          // vertex and point deltas
  localparam int W2 = 2 * W1;                  // products
  localparam int W3 = W2 + 1;                  // edge value at the point
  localparam int NW = W3 + 2;                  // edge value at a neighbor
  localparam int BW = ((INDEX_BITS > REG_BITS) ? INDEX_BITS : REG_BITS) + 1;

  // ---------------------------------------------------------------- registers
  screen_max_t screen_x_max_r, screen_y_max_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_x_max_r <= SCREEN_X_MAX_RST;
      screen_y_max_r <= SCREEN_Y_MAX_RST;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == CFG_SCREEN_X_MAX) begin
        screen_x_max_r <= cfg_chan.data;
      end
      if (cfg_chan.index == CFG_SCREEN_Y_MAX) begin
        screen_y_max_r <= cfg_chan.data;
      end
    end
  end

  // ---------------------------------------------------------------- flow control
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en        = !out_valid_r || out_chan.ready;
  assign s3_en         = !s3_valid_r || out_en;
  assign s2_en         = !s2_valid_r || s3_en;
  assign s1_en         = !s1_valid_r || s2_en;
  assign in_chan.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= in_chan.valid;
      if (s2_en)  s2_valid_r  <= s1_valid_r;
      if (s3_en)  s3_valid_r  <= s2_valid_r;
      if (out_en) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [W1-1:0] vx [3];
  logic signed [W1-1:0] vy [3];
  logic signed [W1-1:0] px_w, py_w;

  logic signed [W1-1:0] s1_ex_nxt [3], s1_ey_nxt [3], s1_dx_nxt [3], s1_dy_nxt [3];
  logic signed [W1-1:0] s1_ex_r [3], s1_ey_r [3], s1_dx_r [3], s1_dy_r [3];
  logic [2:0]           s1_xok_nxt, s1_yok_nxt, s1_xok_r, s1_yok_r;

  logic signed [BW-1:0] ix_w, iy_w, wmax_w, hmax_w, wmax_m1, hmax_m1;

  assign px_w  = W1'(in_chan.point_x);
  assign py_w  = W1'(in_chan.point_y);
  assign vx[0] = W1'(in_chan.vert_a_x);
  assign vy[0] = W1'(in_chan.vert_a_y);
  assign vx[1] = W1'(in_chan.vert_b_x);
  assign vy[1] = W1'(in_chan.vert_b_y);
  assign vx[2] = W1'(in_chan.vert_c_x);
  assign vy[2] = W1'(in_chan.vert_c_y);

  // edge k runs from vertex k to vertex k+1 (wrapping)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_ex_nxt[k] = vx[(k + 1) % 3] - vx[k];
      s1_ey_nxt[k] = vy[(k + 1) % 3] - vy[k];
      s1_dx_nxt[k] = px_w - vx[k];
      s1_dy_nxt[k] = py_w - vy[k];
    end
  end

  // offset -1 needs index >= 1, offset +1 needs index <= max - 1
  assign ix_w    = BW'(in_chan.pixel_col);
  assign iy_w    = BW'(in_chan.pixel_row);
  assign wmax_w  = $signed(BW'(screen_x_max_r));
  assign hmax_w  = $signed(BW'(screen_y_max_r));
  assign wmax_m1 = wmax_w - BW'(1);
  assign hmax_m1 = hmax_w - BW'(1);

  assign s1_xok_nxt[0] = ix_w > $signed(BW'(0));
  assign s1_xok_nxt[1] = (ix_w >= $signed(BW'(0))) && (ix_w <= wmax_w);
  assign s1_xok_nxt[2] = ix_w <= wmax_m1;
  assign s1_yok_nxt[0] = iy_w > $signed(BW'(0));
  assign s1_yok_nxt[1] = (iy_w >= $signed(BW'(0))) && (iy_w <= hmax_w);
  assign s1_yok_nxt[2] = iy_w <= hmax_m1;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ex_r  <= s1_ex_nxt;
      s1_ey_r  <= s1_ey_nxt;
      s1_dx_r  <= s1_dx_nxt;
      s1_dy_r  <= s1_dy_nxt;
      s1_xok_r <= s1_xok_nxt;
      s1_yok_r <= s1_yok_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [W2-1:0] s2_pa_nxt [3], s2_pb_nxt [3], s2_pa_r [3], s2_pb_r [3];
  logic signed [W1-1:0] s2_ex_r [3], s2_ey_r [3];
  logic [2:0]           s2_xok_r, s2_yok_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_pa_nxt[k] = W2'(s1_ex_r[k]) * W2'(s1_dy_r[k]);
      s2_pb_nxt[k] = W2'(s1_ey_r[k]) * W2'(s1_dx_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_pa_r  <= s2_pa_nxt;
      s2_pb_r  <= s2_pb_nxt;
      s2_ex_r  <= s1_ex_r;
      s2_ey_r  <= s1_ey_r;
      s2_xok_r <= s1_xok_r;
      s2_yok_r <= s1_yok_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [W3-1:0] s3_e_nxt [3], s3_e_r [3];
  logic signed [W1-1:0] s3_ex_r [3], s3_ey_r [3];
  logic [2:0]           s3_xok_r, s3_yok_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_e_nxt[k] = W3'(s2_pa_r[k]) - W3'(s2_pb_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_e_r   <= s3_e_nxt;
      s3_ex_r  <= s2_ex_r;
      s3_ey_r  <= s2_ey_r;
      s3_xok_r <= s2_xok_r;
      s3_yok_r <= s2_yok_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // neighbor (u, v): e + v*ex - u*ey, with u, v in {-1, 0, +1}
  cover_mask_t          mask_nxt, mask_r;
  logic                 centre_nxt, centre_r;
  logic signed [NW-1:0] f_val;
  logic signed [NW-1:0] tv, tu;
  logic [2:0]           neg;

  always_comb begin
    mask_nxt = '0;
    f_val    = '0;
    tv       = '0;
    tu       = '0;
    neg      = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          if (r == 0)      tv = -NW'(s3_ex_r[k]);
          else if (r == 2) tv = NW'(s3_ex_r[k]);
          else             tv = '0;
          if (c == 0)      tu = NW'(s3_ey_r[k]);
          else if (c == 2) tu = -NW'(s3_ey_r[k]);
          else             tu = '0;
          f_val  = NW'(s3_e_r[k]) + tv + tu;
          neg[k] = f_val[NW-1];
        end
        // either winding counts, zero is non-negative
        mask_nxt[3 * r + c] = ((neg == 3'b000) || (neg == 3'b111))
                              && s3_xok_r[c] && s3_yok_r[r];
      end
    end
  end

  assign centre_nxt = s3_xok_r[1] && s3_yok_r[1];

  always_ff @(posedge clk) begin
    if (out_en) begin
      mask_r   <= mask_nxt;
      centre_r <= centre_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.cover_mask       = mask_r;
  assign out_chan.centre_in_screen = centre_r;

  // ---------------------------------------------------------------- checks
  // the centre neighbor can only be set when the centre index is on screen
  a_centre_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!mask_r[4] || centre_r))
    else $error("centre mask bit set with centre off screen");

  // an accepted item always lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_valid_r)
    else $error("accepted item did not enter the pipe");

  // a blocked stage 3 keeps its item
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !s3_en) |=> (s3_valid_r && $stable(s3_e_r[0]) && $stable(s3_xok_r)))
    else $error("stalled stage 3 item changed");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (out_valid_r && $stable(mask_r) && $stable(centre_r)))
    else $error("stalled result changed");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule
